// ===== rtl/core/framed_record_byte_fifo_core_defines.svh =====
// Assertion macros for the record FIFO checkers.
`ifndef FRAMED_RECORD_BYTE_FIFO_CORE_DEFINES_SVH
`define FRAMED_RECORD_BYTE_FIFO_CORE_DEFINES_SVH

// Same-cycle implication, gated off while reset is held.
`define FRBF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, gated off while reset is held.
`define FRBF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== rtl/core/frbf_pkg.sv =====
package frbf_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int BYTE_W        = 8;
    localparam int CAP_W         = 9;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 8;

    // record modes
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_FIXED = 2'd1;
    localparam logic [1:0] MODE_TLV   = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_NO_ROOM = 2'd1;
    localparam logic [1:0] STATUS_EMPTY   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MODE        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RECORD_SIZE = 2'd2;

    localparam logic [BYTE_W-1:0] CAPACITY_RESET    = 8'd255;
    localparam logic [BYTE_W-1:0] RECORD_SIZE_RESET = 8'd1;

    typedef enum logic {
        OP_PUSH,
        OP_POP
    } op_t;

    // framing position inside a record
    typedef enum logic [1:0] {
        POS_START,
        POS_TYPE,
        POS_BODY
    } pos_t;

    typedef struct packed {
        logic              req_type;
        logic [BYTE_W-1:0] data_in;
    } in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [BYTE_W-1:0] data_out;
        logic              record_last;
        logic [BYTE_W-1:0] fill_level;
        logic [BYTE_W-1:0] record_count;
    } out_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
    } q_item_t;

    // front to back request
    typedef struct packed {
        logic    valid;
        q_item_t item;
    } fe_req_t;

endpackage

// ===== rtl/core/frbf_front.sv =====
module frbf_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  frbf_pkg::in_t    s_data,
    output frbf_pkg::fe_req_t fe_req,
    input  logic             fe_ready
);
    import frbf_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    q_item_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push, pop;
    q_item_t             item_in;

    // classify the request into an operation
    always_comb begin
        item_in.op   = s_data.req_type ? OP_POP : OP_PUSH;
        item_in.data = s_data.data_in;
    end

    assign s_ready      = (count_reg != QCNT_W'(QDEPTH));
    assign fe_req.valid = (count_reg != '0);
    assign fe_req.item  = entry_reg[rd_ptr_reg];

    assign push = s_valid && s_ready;
    assign pop  = fe_req.valid && fe_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ===== rtl/core/frbf_back.sv =====
module frbf_back #(
    parameter int DEPTH = frbf_pkg::DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [frbf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [frbf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  frbf_pkg::fe_req_t                   fe_req,
    output logic                                fe_ready,
    output logic                                m_valid,
    input  logic                                m_ready,
    output frbf_pkg::out_t                      m_data
);
    import frbf_pkg::*;

    localparam int                PTR_W     = $clog2(DEPTH);
    localparam logic [CAP_W-1:0]  DEPTH_CAP = CAP_W'(DEPTH);

    // configuration
    logic [1:0]        mode_reg;
    logic [BYTE_W-1:0] cap_reg;
    logic [BYTE_W-1:0] rsize_reg;
    logic              cfg_clear;

    // ring and framing state
    logic [BYTE_W-1:0] ring_mem [DEPTH];
    logic [BYTE_W-1:0] head_reg;
    logic [PTR_W-1:0]  wp_reg, wp_next, rp_reg, rp_next;
    logic [BYTE_W-1:0] stored_reg, stored_next;
    logic [BYTE_W-1:0] tlv_reg, tlv_next;
    logic [BYTE_W-1:0] quot_reg, quot_next, rem_reg, rem_next;
    logic [BYTE_W-1:0] push_rem_reg, push_rem_next, pop_rem_reg, pop_rem_next;
    pos_t              push_pos_reg, push_pos_next, pop_pos_reg, pop_pos_next;
    logic              discard_reg, discard_next;

    // result register
    logic              out_valid_reg;
    out_t              out_reg, out_next;

    logic              item_go;
    logic [CAP_W-1:0]  cap_eff, free_b;
    logic [BYTE_W-1:0] esize;
    logic [PTR_W-1:0]  wp_inc1, wp_inc2, rp_inc1;
    logic [2*BYTE_W-1:0] up1, up2, down1;
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [1:0]        n_commit;
    logic              take;
    logic [1:0]        status_c;
    logic              last_c;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] n;
        n = CAP_W'(p) + CAP_W'(1);
        return (n >= cap) ? '0 : n[PTR_W-1:0];
    endfunction

    // quotient/remainder of fill by record size, one byte up
    function automatic logic [2*BYTE_W-1:0] frac_up(input logic [BYTE_W-1:0] quot,
                                                    input logic [BYTE_W-1:0] rem,
                                                    input logic [BYTE_W-1:0] size);
        logic [BYTE_W:0] r;
        r = {1'b0, rem} + (BYTE_W+1)'(1);
        if (r >= {1'b0, size}) begin
            return {quot + BYTE_W'(1), {BYTE_W{1'b0}}};
        end
        return {quot, r[BYTE_W-1:0]};
    endfunction

    // one byte down
    function automatic logic [2*BYTE_W-1:0] frac_down(input logic [BYTE_W-1:0] quot,
                                                      input logic [BYTE_W-1:0] rem,
                                                      input logic [BYTE_W-1:0] size);
        if (rem == '0) begin
            return {(quot != '0) ? quot - BYTE_W'(1) : quot, size - BYTE_W'(1)};
        end
        return {quot, rem - BYTE_W'(1)};
    endfunction

    assign cfg_clear = cfg_wr_en && ((cfg_index == REG_MODE) || (cfg_index == REG_CAPACITY)
                                     || (cfg_index == REG_RECORD_SIZE));

    assign fe_ready = !out_valid_reg || m_ready;
    assign item_go  = fe_req.valid && fe_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    assign cap_eff = (CAP_W'(cap_reg) > DEPTH_CAP) ? DEPTH_CAP : CAP_W'(cap_reg);
    assign esize   = (rsize_reg == '0) ? BYTE_W'(1) : rsize_reg;
    assign free_b  = (CAP_W'(stored_reg) < cap_eff) ? cap_eff - CAP_W'(stored_reg) : '0;
    assign wp_inc1 = ptr_inc(wp_reg, cap_eff);
    assign wp_inc2 = ptr_inc(wp_inc1, cap_eff);
    assign rp_inc1 = ptr_inc(rp_reg, cap_eff);
    assign up1     = frac_up(quot_reg, rem_reg, esize);
    assign up2     = frac_up(up1[2*BYTE_W-1:BYTE_W], up1[BYTE_W-1:0], esize);
    assign down1   = frac_down(quot_reg, rem_reg, esize);

    // next state of framing, pointers and counters
    always_comb begin
        logic [BYTE_W-1:0] rem_v;
        logic              go_v;
        logic [BYTE_W-1:0] b;

        b             = fe_req.item.data;
        rem_v         = '0;
        go_v          = 1'b0;
        push_pos_next = push_pos_reg;
        push_rem_next = push_rem_reg;
        discard_next  = discard_reg;
        pop_pos_next  = pop_pos_reg;
        pop_rem_next  = pop_rem_reg;
        tlv_next      = tlv_reg;
        wr_en         = 1'b0;
        wr_addr       = wp_reg;
        wr_data       = b;
        n_commit      = 2'd0;
        take          = 1'b0;
        status_c      = STATUS_DONE;
        last_c        = 1'b0;

        if (item_go && (fe_req.item.op == OP_PUSH)) begin
            case (mode_reg)
                MODE_FIXED: begin
                    if (discard_reg) begin
                        rem_v = (push_rem_reg != '0) ? push_rem_reg - BYTE_W'(1) : '0;
                        push_rem_next = rem_v;
                        if (rem_v == '0) begin
                            discard_next  = 1'b0;
                            push_pos_next = POS_START;
                        end
                        status_c = STATUS_NO_ROOM;
                    end else begin
                        go_v  = 1'b1;
                        rem_v = push_rem_reg;
                        if (push_pos_reg == POS_START) begin
                            if (free_b < CAP_W'(esize)) begin
                                // whole record does not fit: drop the rest of it
                                push_rem_next = esize - BYTE_W'(1);
                                if (esize != BYTE_W'(1)) begin
                                    discard_next  = 1'b1;
                                    push_pos_next = POS_BODY;
                                end
                                status_c = STATUS_NO_ROOM;
                                go_v     = 1'b0;
                            end else begin
                                rem_v = esize;
                            end
                        end
                        if (go_v) begin
                            if (free_b == '0) begin
                                push_rem_next = rem_v;
                                status_c      = STATUS_NO_ROOM;
                            end else begin
                                wr_en         = 1'b1;
                                n_commit      = 2'd1;
                                rem_v         = rem_v - BYTE_W'(1);
                                push_rem_next = rem_v;
                                if (rem_v == '0) begin
                                    push_pos_next = POS_START;
                                    last_c        = 1'b1;
                                end else begin
                                    push_pos_next = POS_BODY;
                                end
                            end
                        end
                    end
                end
                MODE_TLV: begin
                    case (push_pos_reg)
                        POS_START: begin
                            push_pos_next = POS_TYPE;
                            if (free_b < CAP_W'(2)) begin
                                discard_next = 1'b1;
                                status_c     = STATUS_NO_ROOM;
                            end else begin
                                // type byte parked in its slot, not yet counted
                                wr_en = 1'b1;
                            end
                        end
                        POS_TYPE: begin
                            push_rem_next = b;
                            if (discard_reg || (free_b < CAP_W'(b) + CAP_W'(2))) begin
                                discard_next  = (b != '0);
                                push_pos_next = (b != '0) ? POS_BODY : POS_START;
                                status_c      = STATUS_NO_ROOM;
                            end else begin
                                wr_en    = 1'b1;
                                wr_addr  = wp_inc1;
                                n_commit = 2'd2;
                                if (b == '0) begin
                                    push_pos_next = POS_START;
                                    last_c        = 1'b1;
                                    tlv_next = (tlv_reg != '1) ? tlv_reg + BYTE_W'(1) : tlv_reg;
                                end else begin
                                    push_pos_next = POS_BODY;
                                end
                            end
                        end
                        default: begin
                            rem_v = (push_rem_reg != '0) ? push_rem_reg - BYTE_W'(1) : '0;
                            if (discard_reg) begin
                                push_rem_next = rem_v;
                                if (rem_v == '0) begin
                                    discard_next  = 1'b0;
                                    push_pos_next = POS_START;
                                end
                                status_c = STATUS_NO_ROOM;
                            end else if (free_b == '0) begin
                                status_c = STATUS_NO_ROOM;
                            end else begin
                                wr_en         = 1'b1;
                                n_commit      = 2'd1;
                                push_rem_next = rem_v;
                                if (rem_v == '0) begin
                                    push_pos_next = POS_START;
                                    last_c        = 1'b1;
                                    tlv_next = (tlv_reg != '1) ? tlv_reg + BYTE_W'(1) : tlv_reg;
                                end else begin
                                    push_pos_next = POS_BODY;
                                end
                            end
                        end
                    endcase
                end
                default: begin
                    if (free_b == '0) begin
                        status_c = STATUS_NO_ROOM;
                    end else begin
                        wr_en    = 1'b1;
                        n_commit = 2'd1;
                        last_c   = 1'b1;
                    end
                end
            endcase
        end else if (item_go) begin
            if (stored_reg == '0) begin
                pop_pos_next = POS_START;
                pop_rem_next = '0;
                status_c     = STATUS_EMPTY;
            end else begin
                take = 1'b1;
                case (mode_reg)
                    MODE_FIXED: begin
                        rem_v = (pop_pos_reg == POS_START) ? esize : pop_rem_reg;
                        rem_v = (rem_v != '0) ? rem_v - BYTE_W'(1) : rem_v;
                        pop_rem_next = rem_v;
                        if (rem_v == '0) begin
                            pop_pos_next = POS_START;
                            last_c       = 1'b1;
                        end else begin
                            pop_pos_next = POS_BODY;
                        end
                    end
                    MODE_TLV: begin
                        if (pop_pos_reg == POS_START) begin
                            pop_pos_next = POS_TYPE;
                        end else begin
                            if (pop_pos_reg == POS_TYPE) begin
                                rem_v = head_reg;
                            end else begin
                                rem_v = (pop_rem_reg != '0) ? pop_rem_reg - BYTE_W'(1) : '0;
                            end
                            pop_rem_next = rem_v;
                            if (rem_v == '0) begin
                                pop_pos_next = POS_START;
                                last_c       = 1'b1;
                                tlv_next = (tlv_reg != '0) ? tlv_reg - BYTE_W'(1) : tlv_reg;
                            end else begin
                                pop_pos_next = POS_BODY;
                            end
                        end
                    end
                    default: begin
                        last_c = 1'b1;
                    end
                endcase
            end
        end

        // pointers and fill bookkeeping
        case (n_commit)
            2'd1: begin
                wp_next   = wp_inc1;
                quot_next = up1[2*BYTE_W-1:BYTE_W];
                rem_next  = up1[BYTE_W-1:0];
            end
            2'd2: begin
                wp_next   = wp_inc2;
                quot_next = up2[2*BYTE_W-1:BYTE_W];
                rem_next  = up2[BYTE_W-1:0];
            end
            default: begin
                wp_next   = wp_reg;
                quot_next = take ? down1[2*BYTE_W-1:BYTE_W] : quot_reg;
                rem_next  = take ? down1[BYTE_W-1:0] : rem_reg;
            end
        endcase
        rp_next     = take ? rp_inc1 : rp_reg;
        stored_next = stored_reg + BYTE_W'(n_commit) - BYTE_W'(take);

        if (cfg_clear) begin
            wp_next       = '0;
            rp_next       = '0;
            stored_next   = '0;
            tlv_next      = '0;
            quot_next     = '0;
            rem_next      = '0;
            push_pos_next = POS_START;
            pop_pos_next  = POS_START;
            push_rem_next = '0;
            pop_rem_next  = '0;
            discard_next  = 1'b0;
        end
    end

    // result fields
    always_comb begin
        out_next.status       = status_c;
        out_next.data_out     = take ? head_reg : '0;
        out_next.record_last  = last_c;
        out_next.fill_level   = stored_next;
        out_next.record_count = (mode_reg == MODE_TLV) ? tlv_next : quot_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_PLAIN;
            cap_reg       <= CAPACITY_RESET;
            rsize_reg     <= RECORD_SIZE_RESET;
            wp_reg        <= '0;
            rp_reg        <= '0;
            stored_reg    <= '0;
            tlv_reg       <= '0;
            quot_reg      <= '0;
            rem_reg       <= '0;
            push_pos_reg  <= POS_START;
            pop_pos_reg   <= POS_START;
            push_rem_reg  <= '0;
            pop_rem_reg   <= '0;
            discard_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            stored_reg    <= stored_next;
            tlv_reg       <= tlv_next;
            quot_reg      <= quot_next;
            rem_reg       <= rem_next;
            push_pos_reg  <= push_pos_next;
            pop_pos_reg   <= pop_pos_next;
            push_rem_reg  <= push_rem_next;
            pop_rem_reg   <= pop_rem_next;
            discard_reg   <= discard_next;
            if (item_go) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MODE:        mode_reg  <= cfg_wdata[1:0];
                    REG_CAPACITY:    cap_reg   <= cfg_wdata;
                    REG_RECORD_SIZE: rsize_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_go) begin
            out_reg <= out_next;
        end
    end

    // ring: one write port, head register always holds the byte at the read pointer
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rp_next)) begin
            head_reg <= wr_data;
        end else begin
            head_reg <= ring_mem[rp_next];
        end
    end

endmodule

// ===== rtl/core/framed_record_byte_fifo_core.sv =====
// Framed record byte FIFO. A circular byte buffer of up to DEPTH bytes (the
// capacity register sets the wrap point) with one push or pop byte per
// transaction on the s_ channel and one result transaction per input on the
// m_ channel, in order. Modes: plain bytes, fixed-size records (room for the
// whole record is checked at its first byte; a rejected record swallows its
// remaining bytes with status "no room"), or type-length-value records (the
// type byte is parked in the ring and counted only once the length byte shows
// len+2 bytes fit). Every result reports fill level and the record count (TLV
// records stored, or fill / record_size in the other modes). A pop on an empty
// buffer returns status "empty" and restarts pop framing. Throughput is one
// transaction per clock sustained while m_ready stays high; a taken input
// first lands in the two-entry queue, and when the engine takes it from the
// queue it updates the ring and loads the output register, which presents
// the result. The ring has one write port and one read port that keeps the
// head byte registered, so each byte costs a single ring access. Any register
// write re-initializes pointers, fill and framing; ring contents are kept and
// no clearing pass runs after reset. Write configuration only while idle.
module framed_record_byte_fifo_core #(
    parameter int DEPTH = frbf_pkg::DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [frbf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [frbf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // request channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  frbf_pkg::in_t                    s_data,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output frbf_pkg::out_t                   m_data
);
    import frbf_pkg::*;

    fe_req_t fe_req;   // queued, classified request
    logic    fe_ready; // engine can take a request this clock

    // Front: accepts transactions into a two-entry queue and tags push vs. pop,
    // so a blocked result stalls the requester only once both entries are full.
    frbf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .fe_req   (fe_req),
        .fe_ready (fe_ready)
    );

    // Back: configuration, ring memory, framing state and the result register.
    frbf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fe_req    (fe_req),
        .fe_ready  (fe_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== rtl/core/frbf_checker.sv =====
`include "framed_record_byte_fifo_core_defines.svh"

module frbf_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input frbf_pkg::out_t m_data
);
    import frbf_pkg::*;

    // a stalled result holds
    `FRBF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // an empty pop carries no byte and means nothing is stored
    `FRBF_ASSERT_NOW(a_empty_clean, aclk, aresetn, m_valid && (m_data.status == STATUS_EMPTY), (m_data.fill_level == '0) && (m_data.data_out == '0) && !m_data.record_last)

    // a rejected byte never closes a record or returns data
    `FRBF_ASSERT_NOW(a_reject_clean, aclk, aresetn, m_valid && (m_data.status == STATUS_NO_ROOM), (m_data.data_out == '0) && !m_data.record_last)

endmodule

bind framed_record_byte_fifo_core frbf_checker u_frbf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
